@@ src/png_pcp_pkg.sv @@
// Shared types and constants for the PNG palette chunk parser.
// No dependencies; imported by every module under src.
package png_pcp_pkg;

	typedef enum logic [2:0] {
		PH_SIG  = 3'd0,
		PH_LEN  = 3'd1,
		PH_TYPE = 3'd2,
		PH_DATA = 3'd3,
		PH_CRC  = 3'd4,
		PH_DONE = 3'd5
	} phase_t;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_BAD_SIG     = 4'd1,
		ST_TRUNCATED   = 4'd2,
		ST_BAD_HDR_LEN = 4'd3,
		ST_BAD_PAL_LEN = 4'd4,
		ST_NO_HEADER   = 4'd5,
		ST_NO_PALETTE  = 4'd6,
		ST_NOT_8BIT    = 4'd7,
		ST_NOT_INDEXED = 4'd8
	} status_t;

	localparam logic RK_ENTRY  = 1'b0;
	localparam logic RK_STATUS = 1'b1;

	localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
	localparam logic [31:0] TYPE_PLTE = 32'h504C_5445;
	localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

	localparam logic [31:0] IHDR_LEN       = 32'd13;
	localparam logic [7:0]  DEPTH_8BIT     = 8'd8;
	localparam logic [7:0]  CTYPE_INDEXED  = 8'd3;

	typedef struct packed {
		logic        kind;
		logic [7:0]  entry_index;
		logic [23:0] rgb_color;
		status_t     status;
		logic [31:0] image_width;
		logic [31:0] image_height;
		logic [8:0]  entry_count;
	} result_t;

	// PNG file signature, one byte per position
	function automatic logic [7:0] sig_byte(input logic [2:0] pos);
		logic [7:0] b;
		case (pos)
			3'd0: b = 8'd137;
			3'd1: b = 8'd80;
			3'd2: b = 8'd78;
			3'd3: b = 8'd71;
			3'd4: b = 8'd13;
			3'd5: b = 8'd10;
			3'd6: b = 8'd26;
			3'd7: b = 8'd10;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

@@ src/png_pcp_parser.sv @@
// Byte-wise chunk walker: state registers and the per-byte update logic.
// Depends on png_pcp_pkg; drives one candidate result per accepted byte.
module png_pcp_parser
	import png_pcp_pkg::*;
#(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  logic [7:0] data_byte,
	input  logic    last,
	output logic    res_valid,
	output result_t res
);

	localparam logic [31:0] PAL_MAX_LEN = 32'(3 * PALETTE_ENTRIES);

	phase_t      phase_q, phase_d;
	logic [31:0] cnt_q, cnt_d, cnt_inc;
	logic [31:0] len_q, len_d;
	logic [31:0] type_q, type_d, type_new;
	logic [31:0] width_q, width_d;
	logic [31:0] height_q, height_d;
	logic [7:0]  depth_q, depth_d;
	logic [7:0]  ctype_q, ctype_d;
	logic        hdr_seen_q, hdr_seen_d;
	logic        pal_seen_q, pal_seen_d;
	logic [8:0]  pal_cnt_q, pal_cnt_d;
	logic [23:0] acc_q, acc_d;
	logic [1:0]  len_mod3_q, len_mod3_d;
	logic [1:0]  col_mod3_q, col_mod3_d;

	logic        fin, entry;
	status_t     st;
	logic [1:0]  len_base;

	// (base + byte) mod 3; 256 = 1 mod 3 so the running length residue just adds
	function automatic logic [1:0] mod3_add(input logic [1:0] base, input logic [7:0] b);
		logic [3:0] s;
		logic [2:0] t;
		s = {2'b00, b[1:0]} + {2'b00, b[3:2]} + {2'b00, b[5:4]} + {2'b00, b[7:6]}
			+ {2'b00, base};
		t = {1'b0, s[1:0]} + {1'b0, s[3:2]};
		if (t >= 3'd6) begin
			t = t - 3'd6;
		end else if (t >= 3'd3) begin
			t = t - 3'd3;
		end
		return t[1:0];
	endfunction

	function automatic status_t final_status(input logic hdr, input logic pal,
		input logic [7:0] ctype, input logic [7:0] depth);
		status_t s;
		if (!hdr) begin
			s = ST_NO_HEADER;
		end else if (ctype == CTYPE_INDEXED) begin
			if (!pal) begin
				s = ST_NO_PALETTE;
			end else if (depth != DEPTH_8BIT) begin
				s = ST_NOT_8BIT;
			end else begin
				s = ST_OK;
			end
		end else begin
			s = ST_NOT_INDEXED;
		end
		return s;
	endfunction

	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		len_d      = len_q;
		type_d     = type_q;
		width_d    = width_q;
		height_d   = height_q;
		depth_d    = depth_q;
		ctype_d    = ctype_q;
		hdr_seen_d = hdr_seen_q;
		pal_seen_d = pal_seen_q;
		pal_cnt_d  = pal_cnt_q;
		acc_d      = acc_q;
		len_mod3_d = len_mod3_q;
		col_mod3_d = col_mod3_q;
		fin        = 1'b0;
		entry      = 1'b0;
		st         = ST_OK;
		cnt_inc    = cnt_q + 32'd1;
		type_new   = {type_q[23:0], data_byte};
		len_base   = (cnt_q[1:0] == 2'd0) ? 2'd0 : len_mod3_q;

		case (phase_q)
			PH_SIG: begin
				if (data_byte != sig_byte(cnt_q[2:0])) begin
					fin = 1'b1;
					st  = ST_BAD_SIG;
				end else begin
					cnt_d = cnt_inc;
					if (cnt_q[2:0] == 3'd7) begin
						phase_d = PH_LEN;
						cnt_d   = '0;
					end
				end
			end
			PH_LEN: begin
				len_d      = {len_q[23:0], data_byte};
				len_mod3_d = mod3_add(len_base, data_byte);
				cnt_d      = cnt_inc;
				if (cnt_q[1:0] == 2'd3) begin
					phase_d = PH_TYPE;
					cnt_d   = '0;
				end
			end
			PH_TYPE: begin
				type_d = type_new;
				cnt_d  = cnt_inc;
				if (cnt_q[1:0] == 2'd3) begin
					cnt_d = '0;
					if (type_new == TYPE_IHDR && len_q != IHDR_LEN) begin
						fin = 1'b1;
						st  = ST_BAD_HDR_LEN;
					end else if (type_new == TYPE_PLTE &&
						(len_mod3_q != 2'd0 || len_q > PAL_MAX_LEN)) begin
						fin = 1'b1;
						st  = ST_BAD_PAL_LEN;
					end else begin
						col_mod3_d = 2'd0;
						if (type_new == TYPE_PLTE) begin
							pal_cnt_d = '0;
							acc_d     = '0;
						end
						if (len_q == 32'd0) begin
							if (type_new == TYPE_PLTE) begin
								pal_seen_d = 1'b1;
							end
							phase_d = PH_CRC;
						end else begin
							phase_d = PH_DATA;
						end
					end
				end
			end
			PH_DATA: begin
				if (type_q == TYPE_IHDR) begin
					if (cnt_q < 32'd4) begin
						width_d = {width_q[23:0], data_byte};
					end else if (cnt_q < 32'd8) begin
						height_d = {height_q[23:0], data_byte};
					end else if (cnt_q == 32'd8) begin
						depth_d = data_byte;
					end else if (cnt_q == 32'd9) begin
						ctype_d = data_byte;
					end
				end else if (type_q == TYPE_PLTE) begin
					acc_d = {acc_q[15:0], data_byte};
					if (col_mod3_q == 2'd2) begin
						entry     = 1'b1;
						pal_cnt_d = pal_cnt_q + 9'd1;
					end
				end
				col_mod3_d = (col_mod3_q == 2'd2) ? 2'd0 : col_mod3_q + 2'd1;
				cnt_d      = cnt_inc;
				if (cnt_inc >= len_q) begin
					if (type_q == TYPE_IHDR) begin
						hdr_seen_d = 1'b1;
					end
					if (type_q == TYPE_PLTE) begin
						pal_seen_d = 1'b1;
					end
					phase_d = PH_CRC;
					cnt_d   = '0;
				end
			end
			PH_CRC: begin
				cnt_d = cnt_inc;
				if (cnt_q[1:0] == 2'd3) begin
					cnt_d = '0;
					if (type_q != TYPE_IHDR &&
						((pal_seen_q && hdr_seen_q) || type_q == TYPE_IEND)) begin
						fin = 1'b1;
						st  = final_status(hdr_seen_q, pal_seen_q, ctype_q, depth_q);
					end else begin
						phase_d = PH_LEN;
					end
				end
			end
			PH_DONE: begin
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase

		// end of file before parsing stopped
		if (phase_q != PH_DONE && !fin && last) begin
			fin = 1'b1;
			st  = (phase_d == PH_SIG) ? ST_BAD_SIG : ST_TRUNCATED;
		end
		if (fin) begin
			phase_d = PH_DONE;
		end

		res = '0;
		if (fin) begin
			res.kind         = RK_STATUS;
			res.status       = st;
			res.image_width  = width_d;
			res.image_height = height_d;
			res.entry_count  = pal_cnt_d;
		end else if (entry) begin
			res.kind        = RK_ENTRY;
			res.entry_index = pal_cnt_q[7:0];
			res.rgb_color   = acc_d;
		end
		res_valid = (fin || entry) && phase_q != PH_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SIG;
			cnt_q      <= '0;
			len_q      <= '0;
			type_q     <= '0;
			width_q    <= '0;
			height_q   <= '0;
			depth_q    <= '0;
			ctype_q    <= '0;
			hdr_seen_q <= 1'b0;
			pal_seen_q <= 1'b0;
			pal_cnt_q  <= '0;
			acc_q      <= '0;
			len_mod3_q <= '0;
			col_mod3_q <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			cnt_q      <= cnt_d;
			len_q      <= len_d;
			type_q     <= type_d;
			width_q    <= width_d;
			height_q   <= height_d;
			depth_q    <= depth_d;
			ctype_q    <= ctype_d;
			hdr_seen_q <= hdr_seen_d;
			pal_seen_q <= pal_seen_d;
			pal_cnt_q  <= pal_cnt_d;
			acc_q      <= acc_d;
			len_mod3_q <= len_mod3_d;
			col_mod3_q <= col_mod3_d;
		end
	end

	// once finished, the walker never leaves the done phase
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("parser left done phase");

	// a status report always closes the file
	a_status_ends: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && res.kind == RK_STATUS |=> phase_q == PH_DONE)
		else $error("status report without stopping");

	// signature position never passes the eighth byte
	a_sig_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SIG |-> cnt_q < 32'd8)
		else $error("signature counter overran");

endmodule

@@ src/png_pcp_out_buf.sv @@
// Two-deep result buffer: output register plus skid register.
// Depends on png_pcp_pkg for result_t.
module png_pcp_out_buf
	import png_pcp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    out_v_q, skid_v_q;
	result_t out_q, skid_q;
	logic    load_out;

	assign load_out  = !out_v_q || out_ready;
	assign space     = !skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (load_out) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= push;
			end else begin
				out_v_q  <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds data while output empty");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_v_q)
		else $error("result pushed into full buffer");

	a_drop_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_v_q) |-> $past(out_ready))
		else $error("result lost without transfer");

endmodule

@@ src/png_palette_chunk_parser_unit.sv @@
// Top level of the PNG palette chunk parser: stream ports, walker, result buffer.
// Depends on png_pcp_pkg, png_pcp_parser and png_pcp_out_buf.
//
//  port group  dir  tdata (low bit up)                               tuser / tlast
//  s_*         in   data_byte[7:0]                                   tlast = last
//  m_*         out  entry_index, rgb_color, status, image_width,     tuser = result_kind
//                   image_height, entry_count, 3 zero bits
//
// One byte per cycle while s_tready is high: every transfer on s_* updates the walker
// state in the same cycle and, if it yields a palette entry or the final status, loads the
// result register, or the skid register while m_tready holds back a waiting result.
// s_tready drops only when both result register and skid register are full,
// i.e. after m_tready has been low with two results waiting.
// arst_n clears all control state; the walker restarts at the signature.
// After the status report, further input bytes are accepted and ignored.
module png_palette_chunk_parser_unit
	import png_pcp_pkg::*;
#(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte[7:0]
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// entry_index[7:0], rgb_color[31:8], status[35:32], image_width[67:36],
	// image_height[99:68], entry_count[108:100], zero[111:109]
	output logic [111:0] m_tdata,
	output logic         m_tuser    // result_kind
);

	logic    step;
	logic    res_valid;
	result_t res;
	logic    buf_space;
	result_t out_res;

	// a byte can be taken whenever the buffer can take one more result
	assign s_tready = buf_space;
	assign step     = s_tvalid && s_tready;

	png_pcp_parser #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (s_tdata),
		.last      (s_tlast),
		.res_valid (res_valid),
		.res       (res)
	);

	png_pcp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step && res_valid),
		.push_data (res),
		.space     (buf_space),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tuser = out_res.kind;
	assign m_tdata = {3'b000, out_res.entry_count, out_res.image_height,
		out_res.image_width, out_res.status, out_res.rgb_color, out_res.entry_index};

endmodule
